// File: design/hrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrc_pkg
// shared constants and memory word types of the hamming radius-2 clusterer
// ----------------------------------------------------------------------------
package hrc_pkg;

    localparam int LABEL_WIDTH = 16;
    localparam int NODE_WIDTH  = 12;
    localparam int RANK_WIDTH  = 4;
    localparam int BITS_WIDTH  = 5;
    localparam int CODE_DEPTH  = 1 << LABEL_WIDTH;
    localparam int NODE_DEPTH  = 1 << NODE_WIDTH;
    localparam int PADDR_WIDTH = 3;

    localparam logic [RANK_WIDTH-1:0] RANK_MAX = '1;

    localparam logic REG_LABEL_BITS = 1'b0;
    localparam logic REG_NODE_COUNT = 1'b1;

    localparam logic [BITS_WIDTH-1:0] LABEL_BITS_RESET = BITS_WIDTH'(LABEL_WIDTH);

    typedef struct packed {
        logic                  reached;
        logic [NODE_WIDTH-1:0] leader;
    } code_word_t;

    typedef struct packed {
        logic [RANK_WIDTH-1:0] rank;
        logic [NODE_WIDTH-1:0] parent;
    } set_word_t;

endpackage

// File: design/hamming_radius2_clusterer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_radius2_clusterer_top
// clusters node labels within hamming distance two using a code table and a
// union-find forest, both held in synchronous single-port-read memories
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories and accepts no item meanwhile;
// configuration writes are taken throughout. Each item then probes
// 1 + b + b(b-1)/2 codes for b label bits (137 at 16 bits), plus for each
// merge attempt a root check on each of the two walks, a union-find step
// with path halving on both walks and the linking of the two roots; all of
// this is paced by the one read port of each memory. An item for a node
// beyond node_count probes no code. A result waits in an output register.
module hamming_radius2_clusterer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // label[15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // clusters[11:0], zero[15:12]
    output logic        m_tuser,    // overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [hrc_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PROBE_RD, S_PROBE_CHK, S_FIND_P, S_FIND_G,
        S_UNION, S_UNION2, S_NEXT, S_DONE
    } state_t;

    typedef enum logic [1:0] {PH_OWN, PH_ONE, PH_TWO} phase_t;

    localparam int NW = hrc_pkg::NODE_WIDTH;
    localparam int LW = hrc_pkg::LABEL_WIDTH;
    localparam int BW = hrc_pkg::BITS_WIDTH;

    hrc_pkg::code_word_t code_mem [hrc_pkg::CODE_DEPTH];
    hrc_pkg::set_word_t  set_mem  [hrc_pkg::NODE_DEPTH];

    hrc_pkg::code_word_t code_rdata, code_wdata;
    hrc_pkg::set_word_t  set_rdata, set_wdata;
    logic                code_we, set_we;
    logic [LW-1:0]       code_waddr, code_raddr;
    logic [NW-1:0]       set_waddr, set_raddr;

    state_t              state_reg;
    phase_t              phase_reg;
    logic [LW-1:0]       clr_reg;
    logic [BW-1:0]       label_bits_reg;
    logic [NW-1:0]       node_count_reg;
    logic [NW-1:0]       cluster_count_reg;
    logic [NW:0]         next_node_reg;
    logic [NW-1:0]       node_reg;
    logic [LW-1:0]       code_reg;
    logic [BW-1:0]       bits_reg;
    logic [BW-1:0]       i_reg, k_reg;
    logic                find_a_reg;
    logic [NW-1:0]       n_reg, ra_reg, rb_reg;
    logic [hrc_pkg::RANK_WIDTH-1:0] rk_n_reg, rka_reg, rkb_reg;
    logic                res_over_reg;
    logic                out_valid_reg;
    logic [NW-1:0]       out_clusters_reg;
    logic                out_over_reg;

    logic                cfg_we;
    logic [BW-1:0]       bits_eff;
    logic [LW-1:0]       mask;
    logic [LW-1:0]       probe_addr;
    logic [LW-1:0]       bit_i, bit_k;

    assign pready   = 1'b1;
    assign cfg_we   = psel & penable & pwrite;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(16 - NW)'(0), out_clusters_reg};
    assign m_tuser  = out_over_reg;

    always_comb
    begin
        if (paddr[2] == hrc_pkg::REG_NODE_COUNT)
            prdata = {(32 - NW)'(0), node_count_reg};
        else
            prdata = {(32 - BW)'(0), label_bits_reg};
    end

    always_comb
    begin
        bits_eff = (label_bits_reg > BW'(LW)) ? BW'(LW) : label_bits_reg;
        if (bits_eff == BW'(LW))
            mask = '1;
        else
            mask = (LW'(1) << bits_eff[3:0]) - LW'(1);
        bit_i = LW'(1) << i_reg[3:0];
        bit_k = LW'(1) << k_reg[3:0];
        unique case (phase_reg)
            PH_OWN:  probe_addr = code_reg;
            PH_ONE:  probe_addr = code_reg ^ bit_i;
            PH_TWO:  probe_addr = code_reg ^ bit_i ^ bit_k;
            default: probe_addr = code_reg;
        endcase
    end

    // memory port control
    always_comb
    begin
        code_we    = 1'b0;
        code_waddr = probe_addr;
        code_wdata = code_rdata;
        code_raddr = probe_addr;
        set_we     = 1'b0;
        set_waddr  = n_reg;
        set_wdata  = set_rdata;
        set_raddr  = n_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                code_we    = 1'b1;
                code_waddr = clr_reg;
                code_wdata = '0;
                set_we     = (clr_reg < LW'(hrc_pkg::NODE_DEPTH));
                set_waddr  = clr_reg[NW-1:0];
                set_wdata  = '{rank: '0, parent: clr_reg[NW-1:0]};
            end
            S_PROBE_CHK:
            begin
                set_raddr = code_rdata.leader;
                if (phase_reg == PH_OWN)
                begin
                    code_we    = 1'b1;
                    code_wdata = '{reached: 1'b1,
                                   leader: (code_rdata.leader == '0) ? node_reg
                                                                      : code_rdata.leader};
                end
                else if (code_rdata.leader == '0)
                begin
                    code_we    = 1'b1;
                    code_wdata = '{reached: 1'b0, leader: node_reg};
                end
            end
            S_FIND_P:
            begin
                if (set_rdata.parent == n_reg)
                    set_raddr = node_reg;
                else
                    set_raddr = set_rdata.parent;
            end
            S_FIND_G:
            begin
                set_we    = 1'b1;
                set_waddr = n_reg;
                set_wdata = '{rank: rk_n_reg, parent: set_rdata.parent};
                set_raddr = set_rdata.parent;
            end
            S_UNION:
            begin
                if (ra_reg != rb_reg)
                begin
                    set_we = 1'b1;
                    if (rka_reg < rkb_reg)
                    begin
                        set_waddr = ra_reg;
                        set_wdata = '{rank: rka_reg, parent: rb_reg};
                    end
                    else
                    begin
                        set_waddr = rb_reg;
                        set_wdata = '{rank: rkb_reg, parent: ra_reg};
                    end
                end
            end
            S_UNION2:
            begin
                set_we    = 1'b1;
                set_waddr = ra_reg;
                set_wdata = '{rank: rka_reg + 1'b1, parent: ra_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (code_we)
            code_mem[code_waddr] <= code_wdata;
        code_rdata <= code_mem[code_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (set_we)
            set_mem[set_waddr] <= set_wdata;
        set_rdata <= set_mem[set_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            phase_reg         <= PH_OWN;
            clr_reg           <= '0;
            label_bits_reg    <= hrc_pkg::LABEL_BITS_RESET;
            node_count_reg    <= '0;
            cluster_count_reg <= '0;
            next_node_reg     <= (NW + 1)'(1);
            out_valid_reg     <= 1'b0;
            find_a_reg        <= 1'b0;
            res_over_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        bits_reg  <= bits_eff;
                        code_reg  <= s_tdata & mask;
                        phase_reg <= PH_OWN;
                        node_reg  <= next_node_reg[NW-1:0];
                        if (next_node_reg > {1'b0, node_count_reg})
                        begin
                            res_over_reg <= 1'b1;
                            state_reg    <= S_DONE;
                        end
                        else
                        begin
                            res_over_reg <= 1'b0;
                            state_reg    <= S_PROBE_RD;
                        end
                    end
                end
                S_PROBE_RD:
                    state_reg <= S_PROBE_CHK;
                S_PROBE_CHK:
                begin
                    n_reg      <= code_rdata.leader;
                    find_a_reg <= 1'b1;
                    if (code_rdata.leader != '0 &&
                        (phase_reg == PH_OWN || code_rdata.reached))
                        state_reg <= S_FIND_P;
                    else
                        state_reg <= S_NEXT;
                end
                S_FIND_P:
                begin
                    if (set_rdata.parent == n_reg)
                    begin
                        if (find_a_reg)
                        begin
                            ra_reg     <= n_reg;
                            rka_reg    <= set_rdata.rank;
                            n_reg      <= node_reg;
                            find_a_reg <= 1'b0;
                        end
                        else
                        begin
                            rb_reg    <= n_reg;
                            rkb_reg   <= set_rdata.rank;
                            state_reg <= S_UNION;
                        end
                    end
                    else
                    begin
                        rk_n_reg  <= set_rdata.rank;
                        state_reg <= S_FIND_G;
                    end
                end
                S_FIND_G:
                begin
                    n_reg     <= set_rdata.parent;
                    state_reg <= S_FIND_P;
                end
                S_UNION:
                begin
                    state_reg <= S_NEXT;
                    if (ra_reg != rb_reg)
                    begin
                        if (cluster_count_reg != '0)
                            cluster_count_reg <= cluster_count_reg - 1'b1;
                        if (rka_reg == rkb_reg && rka_reg != hrc_pkg::RANK_MAX)
                            state_reg <= S_UNION2;
                    end
                end
                S_UNION2:
                    state_reg <= S_NEXT;
                S_NEXT:
                begin
                    state_reg <= S_PROBE_RD;
                    unique case (phase_reg)
                        PH_OWN:
                        begin
                            phase_reg <= PH_ONE;
                            i_reg     <= '0;
                            if (bits_reg == '0)
                                state_reg <= S_DONE;
                        end
                        PH_ONE:
                        begin
                            if (i_reg + 1'b1 == bits_reg)
                            begin
                                phase_reg <= PH_TWO;
                                i_reg     <= '0;
                                k_reg     <= BW'(1);
                                if (bits_reg < BW'(2))
                                    state_reg <= S_DONE;
                            end
                            else
                                i_reg <= i_reg + 1'b1;
                        end
                        default:
                        begin
                            if (k_reg + 1'b1 < bits_reg)
                                k_reg <= k_reg + 1'b1;
                            else
                            begin
                                i_reg <= i_reg + 1'b1;
                                k_reg <= i_reg + BW'(2);
                                if (i_reg + BW'(2) >= bits_reg)
                                    state_reg <= S_DONE;
                            end
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_clusters_reg <= cluster_count_reg;
                        out_over_reg     <= res_over_reg;
                        if (!res_over_reg)
                            next_node_reg <= next_node_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (cfg_we)
            begin
                if (paddr[2] == hrc_pkg::REG_LABEL_BITS)
                    label_bits_reg <= pwdata[BW-1:0];
                else
                begin
                    node_count_reg    <= pwdata[NW-1:0];
                    cluster_count_reg <= pwdata[NW-1:0];
                end
            end
        end
    end

endmodule
